/* rtl/core/vap_pkg.sv */
// Shared types and constants for the vertex attribute packer.
// Used by vap_quant_lane, vap_word_serializer and vertex_attribute_packer_unit.
// No dependencies.
package vap_pkg;

  localparam int unsigned FMT_W   = 4;
  localparam int unsigned WORDS_N = 4;

  localparam logic [1:0] KIND_POS   = 2'd0;
  localparam logic [1:0] KIND_UV    = 2'd1;
  localparam logic [1:0] KIND_NORM  = 2'd2;
  localparam logic [1:0] KIND_COLOR = 2'd3;

  localparam logic [FMT_W-1:0] FMT_P2       = 4'd0;
  localparam logic [FMT_W-1:0] FMT_P2_UV16  = 4'd1;
  localparam logic [FMT_W-1:0] FMT_P2_CF    = 4'd2;
  localparam logic [FMT_W-1:0] FMT_P3       = 4'd3;
  localparam logic [FMT_W-1:0] FMT_P3_UV16  = 4'd4;
  localparam logic [FMT_W-1:0] FMT_P3_N10   = 4'd5;
  localparam logic [FMT_W-1:0] FMT_P3_N10C8 = 4'd6;
  localparam logic [FMT_W-1:0] FMT_P3_F     = 4'd7;
  localparam logic [FMT_W-1:0] FMT_P3_FCF   = 4'd8;

  localparam logic [31:0] FLOAT_ZERO = 32'h0000_0000;
  localparam logic [31:0] FLOAT_ONE  = 32'h3F80_0000;

  typedef enum logic [1:0] {
    SCALE_UNORM16 = 2'd0,
    SCALE_SNORM10 = 2'd1,
    SCALE_UNORM8  = 2'd2
  } scale_t;

  // request from the conversion pipeline to the word serializer
  typedef struct packed {
    logic [WORDS_N-1:0][31:0] words;
    logic [2:0]               count;
    logic                     slice_end;
  } ser_req_t;

endpackage

/* rtl/core/vap_quant_lane.sv */
// One component lane: binary32 times a unorm/snorm scale, round to nearest even,
// truncate toward zero, saturate. Three register stages. Depends on vap_pkg.
module vap_quant_lane (
  input  logic           clk,
  input  logic           en,
  input  logic [31:0]    comp,
  input  vap_pkg::scale_t scale,
  output logic [15:0]    q
);
  import vap_pkg::*;

  // stage 1: exact product of the significand and the integer scale
  logic [39:0] s1_prod;
  logic [7:0]  s1_exp;
  logic        s1_sign, s1_nan, s1_inf, s1_tiny;
  scale_t      s1_scale;
  logic [15:0] scale_val;

  always_comb begin
    unique case (scale)
      SCALE_UNORM16: scale_val = 16'd65535;
      SCALE_SNORM10: scale_val = 16'd511;
      SCALE_UNORM8:  scale_val = 16'd255;
      default:       scale_val = 16'd255;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod  <= {16'b0, 1'b1, comp[22:0]} * {24'b0, scale_val};
      s1_exp   <= comp[30:23];
      s1_sign  <= comp[31];
      s1_nan   <= (comp[30:23] == 8'hFF) && (comp[22:0] != 23'b0);
      s1_inf   <= (comp[30:23] == 8'hFF) && (comp[22:0] == 23'b0);
      s1_tiny  <= (comp[30:23] == 8'h00);
      s1_scale <= scale;
    end
  end

  // stage 2: align leading bit to 39 or 38, round to 24 bits
  logic [39:0]       aligned;
  logic [9:0]        align_sh;
  logic              top;
  logic [23:0]       keep;
  logic              guard, sticky;
  logic [24:0]       r_next;
  logic signed [9:0] sh_next;

  always_comb begin
    unique case (s1_scale)
      SCALE_UNORM16: align_sh = 10'd0;
      SCALE_SNORM10: align_sh = 10'd7;
      SCALE_UNORM8:  align_sh = 10'd8;
      default:       align_sh = 10'd8;
    endcase
    aligned = s1_prod << align_sh;
    top     = aligned[39];
    if (top) begin
      keep   = aligned[39:16];
      guard  = aligned[15];
      sticky = |aligned[14:0];
    end else begin
      keep   = aligned[38:15];
      guard  = aligned[14];
      sticky = |aligned[13:0];
    end
    r_next  = {1'b0, keep} + {24'b0, guard & (sticky | keep[0])};
    sh_next = $signed({2'b0, s1_exp}) - 10'sd150 - $signed(align_sh)
              + (top ? 10'sd16 : 10'sd15);
  end

  logic [24:0]       s2_r;
  logic signed [9:0] s2_sh;
  logic              s2_sign, s2_nan, s2_inf, s2_tiny;
  scale_t            s2_scale;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r     <= r_next;
      s2_sh    <= sh_next;
      s2_sign  <= s1_sign;
      s2_nan   <= s1_nan;
      s2_inf   <= s1_inf;
      s2_tiny  <= s1_tiny;
      s2_scale <= s1_scale;
    end
  end

  // stage 3: integer part, then clamp to the lane's range
  logic        zero, big;
  logic [4:0]  amt;
  logic [24:0] shifted;
  logic [16:0] mag;
  logic [9:0]  neg10;
  logic [15:0] q_next;

  always_comb begin
    zero    = s2_nan || s2_tiny || (!s2_inf && (s2_sh < -10'sd24));
    big     = s2_inf || (s2_sh >= -10'sd7);
    amt     = 5'(-s2_sh);
    shifted = s2_r >> amt;
    mag     = shifted[16:0];
    neg10   = 10'(-mag[9:0]);
    q_next  = 16'd0;
    if (!zero) begin
      unique case (s2_scale)
        SCALE_UNORM16: begin
          if (s2_sign)                      q_next = 16'd0;
          else if (big || mag >= 17'd65535) q_next = 16'hFFFF;
          else                              q_next = mag[15:0];
        end
        SCALE_SNORM10: begin
          if (!s2_sign) begin
            if (big || mag >= 17'd511) q_next = 16'd511;
            else                       q_next = {6'b0, mag[9:0]};
          end else begin
            if (big || mag >= 17'd512) q_next = 16'h0200;
            else                       q_next = {6'b0, neg10};
          end
        end
        SCALE_UNORM8: begin
          if (s2_sign)                    q_next = 16'd0;
          else if (big || mag >= 17'd255) q_next = 16'd255;
          else                            q_next = {8'b0, mag[7:0]};
        end
        default: q_next = 16'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

/* rtl/core/vap_word_serializer.sv */
// Holds one converted attribute and emits its words one per cycle while m_tready is high.
// Depends on vap_pkg.
module vap_word_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  vap_pkg::ser_req_t req,
  output logic              req_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,
  output logic              m_tlast,
  output logic [0:0]        m_tuser
);
  import vap_pkg::*;

  logic                     busy;
  logic [WORDS_N-1:0][31:0] words;
  logic [2:0]               count;
  logic [1:0]               idx;
  logic                     slice_end;
  logic                     fin;

  assign fin       = ({1'b0, idx} == count - 3'd1);
  assign req_ready = !busy || (m_tready && fin);
  assign m_tvalid  = busy;
  assign m_tdata   = words[idx];
  assign m_tlast   = fin;
  assign m_tuser   = fin & slice_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (req_valid && req_ready) begin
      // drop requests that carry no words
      busy <= (req.count != 3'd0);
      idx  <= 2'd0;
    end else if (busy && m_tready) begin
      if (fin) busy <= 1'b0;
      else     idx  <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      words     <= req.words;
      count     <= req.count;
      slice_end <= req.slice_end;
    end
  end

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count != 3'd0 && {1'b0, idx} < count))
    else $error("serializer index outside word count");

  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
    (busy && !fin && m_tready) |=> (busy && idx == $past(idx) + 2'd1))
    else $error("serializer lost a word mid item");

  a_user_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("slice end off the final word");

endmodule

/* rtl/core/vertex_attribute_packer_unit.sv */
// Top level of the vertex attribute packer: three-stage conversion pipeline
// feeding a word serializer. Depends on vap_pkg, vap_quant_lane, vap_word_serializer.
//
//  channel  dir  tdata                      tuser                  tlast
//  s_*      in   comp_x,comp_y,comp_z,comp_w attr_kind[1:0],present end_of_slice
//  m_*      out  word                        slice_end              last
//  cfg_*    in   cfg_we / cfg_data = vertex_format (4 bits)
//
// An item passes the multiply, round and clamp stages, then the serializer
// sends its words, one output word per cycle while m_tready is high. The
// serializer port sets the rate: one item per cycle for one-word layouts while
// m_tready is high, four words per float color. Reset clears pipeline valid
// bits, the serializer and vertex_format. A serializer stall with v3 set holds every stage.
module vertex_attribute_packer_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [vap_pkg::FMT_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [127:0]              s_tdata,  // comp_x, comp_y, comp_z, comp_w
  input  logic [2:0]                s_tuser,  // attr_kind[1:0], present
  input  logic                      s_tlast,  // end_of_slice
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [31:0]               m_tdata,  // word
  output logic [0:0]                m_tuser,  // slice_end
  output logic                      m_tlast   // last
);
  import vap_pkg::*;

  typedef struct packed {
    logic [1:0]               kind;
    logic                     have;
    logic [WORDS_N-1:0][31:0] comps;
    logic [FMT_W-1:0]         fmt;
    logic                     slice;
  } meta_t;

  logic [FMT_W-1:0] vertex_format;
  always_ff @(posedge clk) begin
    if (rst)         vertex_format <= FMT_P2;
    else if (cfg_we) vertex_format <= cfg_data;
  end

  logic     en, ser_ready;
  logic     v1, v2, v3;
  meta_t    st1, st2, st3, meta_in;
  scale_t   scale_in;
  ser_req_t req;
  logic [WORDS_N-1:0][15:0] q;

  assign en       = !v3 || ser_ready;
  assign s_tready = en;

  always_comb begin
    meta_in.kind  = s_tuser[1:0];
    meta_in.have  = s_tuser[2];
    meta_in.comps = s_tdata;
    meta_in.fmt   = vertex_format;
    meta_in.slice = s_tlast;
    unique case (s_tuser[1:0])
      KIND_UV:   scale_in = SCALE_UNORM16;
      KIND_NORM: scale_in = SCALE_SNORM10;
      default:   scale_in = SCALE_UNORM8;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1 <= meta_in;
      st2 <= st1;
      st3 <= st2;
    end
  end

  for (genvar g = 0; g < WORDS_N; g++) begin : g_lane
    vap_quant_lane u_lane (
      .clk   (clk),
      .en    (en),
      .comp  (s_tdata[32*g +: 32]),
      .scale (scale_in),
      .q     (q[g])
    );
  end

  // select the words this layout holds for the attribute
  always_comb begin
    logic [31:0] dflt;
    dflt = (st3.kind == KIND_COLOR) ? FLOAT_ONE : FLOAT_ZERO;
    req.slice_end = st3.slice;
    req.count     = 3'd0;
    for (int i = 0; i < WORDS_N; i++) begin
      req.words[i] = st3.have ? st3.comps[i] : dflt;
    end
    unique case (st3.kind)
      KIND_POS: begin
        if (st3.fmt <= FMT_P2_CF)       req.count = 3'd2;
        else if (st3.fmt <= FMT_P3_FCF) req.count = 3'd3;
      end
      KIND_UV: begin
        if (st3.fmt == FMT_P2_UV16 || st3.fmt == FMT_P3_UV16 ||
            st3.fmt == FMT_P3_N10 || st3.fmt == FMT_P3_N10C8) begin
          req.count    = 3'd1;
          req.words[0] = st3.have ? {q[1], q[0]} : 32'd0;
        end else if (st3.fmt == FMT_P3_F || st3.fmt == FMT_P3_FCF) begin
          req.count = 3'd2;
        end
      end
      KIND_NORM: begin
        if (st3.fmt == FMT_P3_N10 || st3.fmt == FMT_P3_N10C8) begin
          req.count    = 3'd1;
          req.words[0] = st3.have ? {2'b0, q[2][9:0], q[1][9:0], q[0][9:0]} : 32'd0;
        end else if (st3.fmt == FMT_P3_F || st3.fmt == FMT_P3_FCF) begin
          req.count = 3'd3;
        end
      end
      KIND_COLOR: begin
        if (st3.fmt == FMT_P3_N10C8) begin
          req.count    = 3'd1;
          req.words[0] = st3.have ? {q[3][7:0], q[2][7:0], q[1][7:0], q[0][7:0]}
                                  : 32'hFFFF_FFFF;
        end else if (st3.fmt == FMT_P2_CF || st3.fmt == FMT_P3_FCF) begin
          req.count = 3'd4;
        end
      end
      default: req.count = 3'd0;
    endcase
  end

  vap_word_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .req_valid (v3),
    .req       (req),
    .req_ready (ser_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !ser_ready) |=> (v3 && st3 == $past(st3)))
    else $error("stalled request changed");

  a_no_accept_stall: assert property (@(posedge clk) disable iff (rst)
    (v3 && !ser_ready) |-> !s_tready)
    else $error("input taken while pipeline stalled");

  a_empty_fmt: assert property (@(posedge clk) disable iff (rst)
    (v3 && st3.fmt > FMT_P3_FCF) |-> (req.count == 3'd0))
    else $error("words for an empty layout");

endmodule

/* tb/sv/vertex_attribute_packer_unit_test.sv */
// Self-checking testbench for vertex_attribute_packer_unit: drives attribute requests,
// predicts packed layout words, and compares every output word. Depends on vap_pkg.
module vertex_attribute_packer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vap_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic        present;
    logic [31:0] comp [4];
    logic        slice_end;
  } attr_req_t;

  typedef struct {
    logic [31:0] word;
    logic        last;
    logic        slice_end;
  } layout_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [FMT_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [127:0]     s_tdata = '0;
  logic [2:0]       s_tuser = '0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [31:0]      m_tdata;
  logic [0:0]       m_tuser;
  logic             m_tlast;

  attr_req_t    pending_attrs[$];
  layout_word_t packed_words[$];
  logic [FMT_W-1:0] layout_sel = FMT_P2;
  int idle_mode = 2;
  int errors = 0;

  vertex_attribute_packer_unit dut (
    .clk, .rst, .cfg_we, .cfg_data, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // binary32 product with round-to-nearest-even, truncated toward zero and saturated
  function automatic int quantize(logic [31:0] b, int unsigned scale, int lo, int hi);
    int e, k, ex, nb;
    logic [63:0] p, r, rem, halfv, mag;
    e = b[30:23];
    if (e == 255) return (b[22:0] != 0) ? 0 : (b[31] ? lo : hi);
    if (e == 0) return 0;
    p = {40'b0, 1'b1, b[22:0]} * 64'(scale);
    nb = 0;
    for (int i = 0; i < 64; i++) if (p[i]) nb = i + 1;
    k = (nb > 24) ? nb - 24 : 0;
    r = p >> k;
    if (k > 0) begin
      rem = p & ((64'd1 << k) - 1);
      halfv = 64'd1 << (k - 1);
      if (rem > halfv || (rem == halfv && r[0])) r++;
    end
    ex = e - 150 + k;
    if (ex >= 0) mag = (ex > 30) ? 64'hFFFF_FFFF : (r << ex);
    else mag = (-ex >= 64) ? 64'd0 : (r >> (-ex));
    if (!b[31]) return (mag >= 64'(hi)) ? hi : int'(mag);
    return (mag >= 64'(-lo)) ? lo : -int'(mag);
  endfunction

  function automatic void predict_layout_words(attr_req_t a);
    logic [31:0] w[4];
    logic [31:0] dflt;
    logic [31:0] q;
    int n = 0;
    dflt = FLOAT_ZERO;
    if (layout_sel > FMT_P3_FCF) return;
    case (a.kind)
      KIND_POS: n = (layout_sel <= FMT_P2_CF) ? 2 : 3;
      KIND_UV: begin
        if (layout_sel == FMT_P2_UV16 || (layout_sel >= FMT_P3_UV16 && layout_sel <= FMT_P3_N10C8)) begin
          w[0] = '0;
          if (a.present) begin
            w[0][15:0]  = 16'(quantize(a.comp[0], 65535, 0, 65535));
            w[0][31:16] = 16'(quantize(a.comp[1], 65535, 0, 65535));
          end
          n = -1;
        end else if (layout_sel >= FMT_P3_F) n = 2;
      end
      KIND_NORM: begin
        if (layout_sel == FMT_P3_N10 || layout_sel == FMT_P3_N10C8) begin
          w[0] = '0;
          if (a.present)
            for (int i = 0; i < 3; i++) begin
              q = 32'(quantize(a.comp[i], 511, -512, 511));
              w[0][10*i +: 10] = q[9:0];
            end
          n = -1;
        end else if (layout_sel >= FMT_P3_F) n = 3;
      end
      default: begin
        if (layout_sel == FMT_P3_N10C8) begin
          w[0] = 32'hFFFF_FFFF;
          if (a.present)
            for (int i = 0; i < 4; i++) w[0][8*i +: 8] = 8'(quantize(a.comp[i], 255, 0, 255));
          n = -1;
        end else if (layout_sel == FMT_P2_CF || layout_sel == FMT_P3_FCF) begin
          n = 4;
          dflt = FLOAT_ONE;
        end
      end
    endcase
    if (n > 0) for (int i = 0; i < n; i++) w[i] = a.present ? a.comp[i] : dflt;
    else if (n < 0) n = 1;
    for (int i = 0; i < n; i++)
      packed_words = {packed_words,
                      layout_word_t'{w[i], i == n - 1, (i == n - 1) ? a.slice_end : 1'b0}};
  endfunction

  function automatic bit idle_now(bit sender);
    if (idle_mode == 2) return 1'b0;
    if ((idle_mode == 0) == sender) return $urandom_range(99) < 33;
    return $urandom_range(99) < 79;
  endfunction

  // drive: advance to the next request once the current one is taken
  always @(posedge clk) begin
    attr_req_t a;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        a.kind = s_tuser[1:0];
        a.present = s_tuser[2];
        for (int i = 0; i < 4; i++) a.comp[i] = s_tdata[32*i +: 32];
        a.slice_end = s_tlast;
        predict_layout_words(a);
      end
      if (pending_attrs.size() > 0 && !idle_now(1'b1)) begin
        a = pending_attrs.pop_front();
        s_tdata <= {a.comp[3], a.comp[2], a.comp[1], a.comp[0]};
        s_tuser <= {a.present, a.kind};
        s_tlast <= a.slice_end;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    layout_word_t x;
    m_tready <= rst ? 1'b0 : !idle_now(1'b0);
    if (!rst && m_tvalid && m_tready) begin
      if (packed_words.size() == 0) begin
        report($sformatf("unexpected word %h", m_tdata));
      end else begin
        x = packed_words.pop_front();
        if (m_tdata !== x.word) report($sformatf("word %h, want %h", m_tdata, x.word));
        if (m_tlast !== x.last) report($sformatf("last %b, want %b", m_tlast, x.last));
        if (m_tuser[0] !== x.slice_end)
          report($sformatf("slice_end %b, want %b", m_tuser[0], x.slice_end));
      end
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(9))
      0, 1: return $urandom();
      2: return {$urandom_range(1) == 1, 8'hFF, 23'(($urandom_range(1) == 1) ? $urandom() : 0)};
      3: return {$urandom_range(1) == 1, 8'd0, 23'($urandom())};
      4: return {$urandom_range(1) == 1, 8'(130 + $urandom_range(20)), 23'($urandom())};
      5: return {1'b0, 8'h7F, 23'd0};
      default: return {$urandom_range(3) == 0, 8'(110 + $urandom_range(17)), 23'($urandom())};
    endcase
  endfunction

  task automatic add_attr(logic [1:0] kind, logic present, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z, logic [31:0] w, logic eos);
    attr_req_t a;
    a.kind = kind;
    a.present = present;
    a.comp[0] = x; a.comp[1] = y; a.comp[2] = z; a.comp[3] = w;
    a.slice_end = eos;
    pending_attrs = {pending_attrs, a};
  endtask

  task automatic drain_and_set_layout(logic [FMT_W-1:0] f);
    while (pending_attrs.size() > 0 || s_tvalid || packed_words.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= f;
    layout_sel = f;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [FMT_W-1:0] layouts[14] = '{FMT_P3_N10C8, FMT_P2, FMT_P2_UV16, FMT_P2_CF, FMT_P3,
      FMT_P3_UV16, FMT_P3_N10, FMT_P3_F, FMT_P3_FCF, 4'd9, 4'd15, FMT_P3_N10C8, FMT_P3_FCF,
      FMT_P2_CF};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 14; p++) begin
      drain_and_set_layout(layouts[p]);
      idle_mode = (p * 3) / 14;
      if (p == 0) begin
        // saturation, NaN, infinities, rounding and absent defaults
        add_attr(KIND_COLOR, 1, 32'h0, 32'h3F80_0000, 32'hBF80_0000, 32'h3F00_0000, 0);
        add_attr(KIND_COLOR, 1, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h4000_0000, 1);
        add_attr(KIND_COLOR, 0, 32'h3F80_0000, 32'h0, 32'h0, 32'h0, 1);
        add_attr(KIND_NORM, 1, 32'h3F80_0000, 32'hBF80_0000, 32'hFF80_0000, 32'h0, 0);
        add_attr(KIND_NORM, 1, 32'h7FC0_0000, 32'h7F80_0000, 32'hBF00_0000, 32'hFFFF_FFFF, 1);
        add_attr(KIND_NORM, 0, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h0, 0);
        add_attr(KIND_UV, 1, 32'h3F80_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'h0, 0);
        add_attr(KIND_UV, 1, 32'hBF00_0000, 32'h7FC0_0000, 32'h0, 32'h0, 1);
        add_attr(KIND_UV, 1, 32'h0000_0001, 32'h3F7F_FFFF, 32'h0, 32'h0, 0);
        add_attr(KIND_UV, 0, 32'h3F80_0000, 32'h3F80_0000, 32'h0, 32'h0, 1);
        add_attr(KIND_POS, 1, 32'hFFFF_FFFF, 32'h7FC0_0000, 32'h8000_0000, 32'h1234_5678, 1);
        add_attr(KIND_POS, 0, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h0, 0);
        add_attr(KIND_COLOR, 1, 32'h3F7F_FFFF, 32'h3B80_8081, 32'h3C00_0000, 32'h0080_0000, 0);
      end
      for (int i = 0; i < 32; i++)
        add_attr(2'($urandom_range(3)), $urandom_range(7) != 0, rand_comp(), rand_comp(),
                 rand_comp(), rand_comp(), $urandom_range(1));
    end
    while (pending_attrs.size() > 0 || s_tvalid || packed_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && packed_words.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/vap_pkg.sv
rtl/core/vap_quant_lane.sv
rtl/core/vap_word_serializer.sv
rtl/core/vertex_attribute_packer_unit.sv
tb/sv/vertex_attribute_packer_unit_test.sv
